[rtl/vcss_pkg.sv]
// Shared types, codes and constants for the vehicle command safety supervisor.
// Used by the controller, the datapath, the top level and the testbench.
package vcss_pkg;

  // Action codes of an input item
  localparam logic [1:0] ACT_CMD_STATE = 2'd0;
  localparam logic [1:0] ACT_CMD       = 2'd1;
  localparam logic [1:0] ACT_REPORT    = 2'd2;
  localparam logic [1:0] ACT_TIMEOUT   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_ACCEL_MIN   = 3'd0;
  localparam logic [2:0] CFG_ACCEL_MAX   = 3'd1;
  localparam logic [2:0] CFG_WA_MIN      = 3'd2;
  localparam logic [2:0] CFG_WA_MAX      = 3'd3;
  localparam logic [2:0] CFG_SPEED_LIMIT = 3'd4;
  localparam logic [2:0] CFG_STEP_US     = 3'd5;
  localparam logic [2:0] CFG_TIMEOUT_US  = 3'd6;
  localparam logic [2:0] CFG_DEADZONE    = 3'd7;

  // Gear codes
  localparam logic [2:0] GR_NONE = 3'd0;
  localparam logic [2:0] GR_DRV  = 3'd1;
  localparam logic [2:0] GR_RVS  = 3'd2;
  localparam logic [2:0] GR_PRK  = 3'd3;
  localparam logic [2:0] GR_LO   = 3'd4;
  localparam logic [2:0] GR_NEU  = 3'd5;

  // Headlight codes
  localparam logic [2:0] HL_NONE = 3'd0;
  localparam logic [2:0] HL_OFF  = 3'd1;
  localparam logic [2:0] HL_LOW  = 3'd2;
  localparam logic [2:0] HL_HIGH = 3'd3;

  // Blinker codes
  localparam logic [2:0] BL_NONE   = 3'd0;
  localparam logic [2:0] BL_OFF    = 3'd1;
  localparam logic [2:0] BL_HAZARD = 3'd4;

  // Wiper codes
  localparam logic [2:0] WP_NONE  = 3'd0;
  localparam logic [2:0] WP_OFF   = 3'd1;
  localparam logic [2:0] WP_LOW   = 3'd2;
  localparam logic [2:0] WP_HIGH  = 3'd3;
  localparam logic [2:0] WP_CLEAN = 3'd4;

  // Mode codes
  localparam logic [1:0] MD_NONE = 2'd0;
  localparam logic [1:0] MD_MAN  = 2'd2;
  localparam logic [1:0] MD_NRDY = 2'd3;

  // Pending request slots
  localparam int unsigned PendN         = 7;
  localparam int unsigned PendWiper     = 0;
  localparam int unsigned PendBlinker   = 1;
  localparam int unsigned PendGear      = 2;
  localparam int unsigned PendHeadlight = 3;
  localparam int unsigned PendMode      = 4;
  localparam int unsigned PendHorn      = 5;
  localparam int unsigned PendHandBrake = 6;

  // Microseconds per second, and quotient bits of the braking divide
  localparam logic signed [20:0] USecPerSec = 21'sd1000000;
  localparam int unsigned DivSteps = 35;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] accel_cmd;
    logic [15:0] wheel_angle_cmd;
    logic [15:0] speed;
    logic [2:0]  headlight_code;
    logic [2:0]  blinker_code;
    logic [2:0]  wiper_code;
    logic [2:0]  gear_code;
    logic [1:0]  mode_code;
    logic        horn_on;
    logic        hand_brake_on;
    logic [47:0] time_stamp;
  } in_item_t;

  typedef struct packed {
    logic [15:0] accel_out;
    logic [15:0] wheel_angle_out;
    logic        has_state_cmd;
    logic [1:0]  headlight_out;
    logic [2:0]  blinker_out;
    logic [2:0]  wiper_out;
    logic [2:0]  gear_out;
    logic [1:0]  mode_out;
    logic        horn_out;
    logic        hand_brake_out;
    logic [4:0]  report_flags;
    logic [47:0] stamp_out;
  } out_item_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLAMP = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_DLOAD = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic load_clamp;
    logic load_mul;
    logic div_load;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] action;
  } dp_stat_t;

endpackage

[rtl/vcss_ifs.sv]
// Valid/ready channel interfaces: input items, result items and config writes.
// Depends on nothing; payload widths follow the item fields.
interface vcss_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic signed [15:0] accel_cmd;
  logic signed [15:0] wheel_angle_cmd;
  logic signed [15:0] speed;
  logic [2:0]  headlight_code;
  logic [2:0]  blinker_code;
  logic [2:0]  wiper_code;
  logic [2:0]  gear_code;
  logic [1:0]  mode_code;
  logic        horn_on;
  logic        hand_brake_on;
  logic [47:0] time_stamp;
  modport source (output valid, action, accel_cmd, wheel_angle_cmd, speed, headlight_code,
                  blinker_code, wiper_code, gear_code, mode_code, horn_on, hand_brake_on,
                  time_stamp, input ready);
  modport sink (input valid, action, accel_cmd, wheel_angle_cmd, speed, headlight_code,
                blinker_code, wiper_code, gear_code, mode_code, horn_on, hand_brake_on,
                time_stamp, output ready);
endinterface

interface vcss_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] accel_out;
  logic signed [15:0] wheel_angle_out;
  logic        has_state_cmd;
  logic [1:0]  headlight_out;
  logic [2:0]  blinker_out;
  logic [2:0]  wiper_out;
  logic [2:0]  gear_out;
  logic [1:0]  mode_out;
  logic        horn_out;
  logic        hand_brake_out;
  logic [4:0]  report_flags;
  logic [47:0] stamp_out;
  modport source (output valid, accel_out, wheel_angle_out, has_state_cmd, headlight_out,
                  blinker_out, wiper_out, gear_out, mode_out, horn_out, hand_brake_out,
                  report_flags, stamp_out, input ready);
  modport sink (input valid, accel_out, wheel_angle_out, has_state_cmd, headlight_out,
                blinker_out, wiper_out, gear_out, mode_out, horn_out, hand_brake_out,
                report_flags, stamp_out, output ready);
endinterface

interface vcss_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/vcss_ctrl.sv]
// Sequencing state machine of the supervisor: input beat, clamp, multiply,
// braking divide and result beat. Depends on vcss_pkg.
module vcss_ctrl import vcss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e     state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic [5:0] cnt_q, cnt_d;

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd_o.load_clamp = 1'b1;
        state_d          = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.load_mul = 1'b1;
        state_d        = (stat_i.action == ACT_TIMEOUT) ? ST_DLOAD : ST_FIN;
      end
      ST_DLOAD: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 6'd1;
        if (cnt_q == 6'(DivSteps - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result beat until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.finish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/vcss_dp.sv]
// Datapath of the supervisor: config registers, vehicle state, pending requests,
// clamp, multipliers, restoring divider and result register. Depends on vcss_pkg.
module vcss_dp import vcss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  in_item_t    item_i,
  output out_item_t   res_o
);

  // Config registers
  logic signed [15:0] accel_min_q, wa_min_q;
  logic [14:0] accel_max_q, wa_max_q, speed_lim_q, deadzone_q;
  logic [19:0] step_q;
  logic [31:0] timeout_q;

  // Vehicle state
  logic [2:0] cur_gear_q, cur_blinker_q, cur_wiper_q;
  logic [1:0] cur_headlight_q, cur_mode_q, cur_flags_q;
  logic signed [15:0] cur_speed_q;
  logic [2:0]  pend_val_q [PendN];
  logic [47:0] pend_stamp_q [PendN];
  logic [2:0]  pend_val_d [PendN];
  logic [47:0] pend_stamp_d [PendN];

  // Work registers
  in_item_t item_q;
  logic signed [15:0] a_o_q, w_o_q;
  logic hit_q;
  logic signed [36:0] pv_q, pa_q;
  logic [19:0] rem_q;
  logic [34:0] quo_q;
  out_item_t res_q, res_d;

  // Combinational signals
  logic [19:0] step_us;
  logic signed [16:0] acc_x, wa_x, amin_x, amax_x, wmin_x, wmax_x;
  logic signed [15:0] a_c, w_c;
  logic a_hit, w_hit;
  logic signed [36:0] pv, pa, nmag;
  logic [20:0] trial;
  logic div_ge;
  logic signed [36:0] q_raw, amin_q, amax_q;
  logic signed [15:0] q_c;
  logic signed [16:0] a17, mag17, spd17, lim17;
  logic signed [37:0] vn;
  logic over, mag_lt, same_sign, flips, as_core;
  logic [2:0] as_gear;
  logic [2:0] hl_s, bl_s, wp_s, gr_s, hl_f, g0, gr0, g1;
  logic [1:0] md_s;
  logic bad, forced, gbad, to_any;
  logic [2:0] cmd_v [PendN];
  logic [2:0] cur_v [PendN];
  logic [2:0] rep_v [PendN];
  logic late_v [PendN];

  assign stat_o.action = item_q.action;
  assign res_o         = res_q;
  assign step_us       = (step_q == '0) ? 20'd1 : step_q;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_min_q <= -16'sd768;
      accel_max_q <= 15'd768;
      wa_min_q    <= -16'sd4096;
      wa_max_q    <= 15'd4096;
      speed_lim_q <= 15'd128;
      step_q      <= 20'd100000;
      timeout_q   <= 32'd3000000;
      deadzone_q  <= 15'd128;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACCEL_MIN:   accel_min_q <= cfg_data_i[15:0];
        CFG_ACCEL_MAX:   accel_max_q <= cfg_data_i[14:0];
        CFG_WA_MIN:      wa_min_q    <= cfg_data_i[15:0];
        CFG_WA_MAX:      wa_max_q    <= cfg_data_i[14:0];
        CFG_SPEED_LIMIT: speed_lim_q <= cfg_data_i[14:0];
        CFG_STEP_US:     step_q      <= cfg_data_i[19:0];
        CFG_TIMEOUT_US:  timeout_q   <= cfg_data_i;
        CFG_DEADZONE:    deadzone_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Clamp acceleration and wheel angle; minimum check wins
  always_comb begin
    acc_x  = {item_q.accel_cmd[15], item_q.accel_cmd};
    wa_x   = {item_q.wheel_angle_cmd[15], item_q.wheel_angle_cmd};
    amin_x = {accel_min_q[15], accel_min_q};
    amax_x = {2'b00, accel_max_q};
    wmin_x = {wa_min_q[15], wa_min_q};
    wmax_x = {2'b00, wa_max_q};
    a_hit  = 1'b1;
    w_hit  = 1'b1;
    if (acc_x < amin_x) a_c = accel_min_q;
    else if (acc_x > amax_x) a_c = {1'b0, accel_max_q};
    else begin
      a_c   = item_q.accel_cmd;
      a_hit = 1'b0;
    end
    if (wa_x < wmin_x) w_c = wa_min_q;
    else if (wa_x > wmax_x) w_c = {1'b0, wa_max_q};
    else begin
      w_c   = item_q.wheel_angle_cmd;
      w_hit = 1'b0;
    end
  end

  // Speed and acceleration scaled to a common time base
  assign pv = cur_speed_q * USecPerSec;
  assign pa = a_o_q * $signed({1'b0, step_us});

  // One quotient bit per step
  assign nmag   = (pv_q < 0) ? -pv_q : pv_q;
  assign trial  = {rem_q, quo_q[34]};
  assign div_ge = trial >= {1'b0, step_us};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) item_q <= item_i;
    if (cmd_i.load_clamp) begin
      a_o_q <= a_c;
      w_o_q <= w_c;
      hit_q <= a_hit | w_hit;
    end
    if (cmd_i.load_mul) begin
      pv_q <= pv;
      pa_q <= pa;
    end
    if (cmd_i.div_load) begin
      rem_q <= '0;
      quo_q <= nmag[34:0];
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? 20'(trial - {1'b0, step_us}) : trial[19:0];
      quo_q <= {quo_q[33:0], div_ge};
    end
    if (cmd_i.finish) res_q <= res_d;
  end

  // Braking command, negated and clamped
  always_comb begin
    q_raw  = (pv_q > 0) ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
    amin_q = 37'(accel_min_q);
    amax_q = $signed({22'd0, accel_max_q});
    if (q_raw < amin_q) q_c = accel_min_q;
    else if (q_raw > amax_q) q_c = {1'b0, accel_max_q};
    else q_c = q_raw[15:0];
  end

  // Automatic drive/reverse shift near standstill
  always_comb begin
    a17       = {a_o_q[15], a_o_q};
    mag17     = (a17 < 0) ? -a17 : a17;
    spd17     = {cur_speed_q[15], cur_speed_q};
    lim17     = {2'b00, speed_lim_q};
    over      = (spd17 > lim17) || (spd17 < -lim17);
    mag_lt    = mag17 < $signed({2'b00, deadzone_q});
    same_sign = (a_o_q > 0 && cur_speed_q > 0) || (a_o_q < 0 && cur_speed_q < 0);
    vn        = 38'(pv_q) + 38'(pa_q);
    flips     = (cur_speed_q > 0 && vn < 0) || (cur_speed_q < 0 && vn > 0);
    as_core   = !mag_lt && !over && !same_sign && (cur_speed_q == 0 || flips);
    as_gear   = (a_o_q > 0) ? GR_DRV : GR_RVS;
  end

  // Sanitize the state request
  always_comb begin
    bad    = 1'b0;
    forced = 1'b0;
    hl_s   = item_q.headlight_code;
    bl_s   = item_q.blinker_code;
    wp_s   = item_q.wiper_code;
    gr_s   = item_q.gear_code;
    md_s   = item_q.mode_code;
    if (hl_s > HL_HIGH) begin hl_s = HL_NONE; bad = 1'b1; end
    if (bl_s > BL_HAZARD) begin bl_s = BL_NONE; bad = 1'b1; end
    if (wp_s > WP_CLEAN) begin wp_s = WP_NONE; bad = 1'b1; end
    if (gr_s > GR_NEU) begin gr_s = GR_NONE; bad = 1'b1; end
    if (md_s > MD_MAN) begin md_s = MD_NONE; bad = 1'b1; end
    hl_f = hl_s;
    if ((wp_s == WP_LOW || wp_s == WP_HIGH) && hl_s <= HL_OFF) begin
      hl_f   = HL_LOW;
      forced = 1'b1;
    end
    g0   = (gr_s == GR_PRK || !as_core) ? gr_s : as_gear;
    gr0  = (g0 == cur_gear_q) ? GR_NONE : g0;
    gbad = (gr0 != GR_NONE) && over;
    if (gbad) gr0 = GR_NONE;
    g1   = (cur_gear_q == GR_PRK || !as_core) ? cur_gear_q : as_gear;
  end

  // Pending request cache and timeout check
  always_comb begin
    cmd_v[PendWiper]     = wp_s;
    cmd_v[PendBlinker]   = bl_s;
    cmd_v[PendGear]      = gr0;
    cmd_v[PendHeadlight] = hl_f;
    cmd_v[PendMode]      = {1'b0, md_s};
    cmd_v[PendHorn]      = {2'b00, item_q.horn_on};
    cmd_v[PendHandBrake] = {2'b00, item_q.hand_brake_on};
    cur_v[PendWiper]     = cur_wiper_q;
    cur_v[PendBlinker]   = cur_blinker_q;
    cur_v[PendGear]      = cur_gear_q;
    cur_v[PendHeadlight] = {1'b0, cur_headlight_q};
    cur_v[PendMode]      = {1'b0, cur_mode_q};
    cur_v[PendHorn]      = {2'b00, cur_flags_q[0]};
    cur_v[PendHandBrake] = {2'b00, cur_flags_q[1]};
    rep_v[PendWiper]     = item_q.wiper_code;
    rep_v[PendBlinker]   = item_q.blinker_code;
    rep_v[PendGear]      = item_q.gear_code;
    rep_v[PendHeadlight] = {1'b0, item_q.headlight_code[1:0]};
    rep_v[PendMode]      = {1'b0, item_q.mode_code};
    rep_v[PendHorn]      = {2'b00, item_q.horn_on};
    rep_v[PendHandBrake] = {2'b00, item_q.hand_brake_on};
    to_any = 1'b0;
    for (int i = 0; i < PendN; i++) begin
      pend_val_d[i]   = pend_val_q[i];
      pend_stamp_d[i] = pend_stamp_q[i];
      late_v[i] = {1'b0, item_q.time_stamp} > ({1'b0, pend_stamp_q[i]} + {17'd0, timeout_q});
      if (item_q.action == ACT_CMD_STATE) begin
        if ((cmd_v[i] != 3'd0 || i >= PendHorn) && cmd_v[i] != cur_v[i]) begin
          pend_val_d[i]   = cmd_v[i];
          pend_stamp_d[i] = item_q.time_stamp;
        end
      end else if (item_q.action == ACT_REPORT) begin
        if (i >= PendHorn) begin
          if (pend_val_q[i] != rep_v[i] && late_v[i]) to_any = 1'b1;
        end else if (pend_val_q[i] != 3'd0) begin
          if (pend_val_q[i] == rep_v[i]) begin
            pend_val_d[i]   = 3'd0;
            pend_stamp_d[i] = '0;
          end else if (late_v[i]) begin
            to_any = 1'b1;
          end
        end
      end
    end
  end

  // Result beat
  always_comb begin
    res_d           = '0;
    res_d.stamp_out = item_q.time_stamp;
    case (item_q.action)
      ACT_CMD_STATE: begin
        res_d.accel_out       = a_o_q;
        res_d.wheel_angle_out = w_o_q;
        res_d.has_state_cmd   = 1'b1;
        res_d.headlight_out   = hl_f[1:0];
        res_d.blinker_out     = bl_s;
        res_d.wiper_out       = wp_s;
        res_d.gear_out        = gr0;
        res_d.mode_out        = md_s;
        res_d.horn_out        = item_q.horn_on;
        res_d.hand_brake_out  = item_q.hand_brake_on;
        res_d.report_flags    = {1'b0, gbad, forced, bad, hit_q};
      end
      ACT_CMD: begin
        res_d.accel_out       = a_o_q;
        res_d.wheel_angle_out = w_o_q;
        res_d.has_state_cmd   = (g1 != cur_gear_q);
        res_d.gear_out        = (g1 != cur_gear_q) ? g1 : GR_NONE;
        res_d.report_flags    = {4'b0000, hit_q};
      end
      ACT_REPORT: begin
        res_d.report_flags = {to_any, 4'b0000};
      end
      ACT_TIMEOUT: begin
        res_d.accel_out     = q_c;
        res_d.has_state_cmd = 1'b1;
        res_d.blinker_out   = BL_HAZARD;
      end
      default: ;
    endcase
  end

  // Vehicle state and pending requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_gear_q      <= GR_DRV;
      cur_blinker_q   <= BL_OFF;
      cur_wiper_q     <= WP_OFF;
      cur_headlight_q <= HL_OFF[1:0];
      cur_mode_q      <= MD_NRDY;
      cur_flags_q     <= '0;
      cur_speed_q     <= '0;
      for (int i = 0; i < PendN; i++) begin
        pend_val_q[i]   <= '0;
        pend_stamp_q[i] <= '0;
      end
    end else if (cmd_i.finish) begin
      if (item_q.action == ACT_REPORT) begin
        cur_gear_q      <= item_q.gear_code;
        cur_blinker_q   <= item_q.blinker_code;
        cur_wiper_q     <= item_q.wiper_code;
        cur_headlight_q <= item_q.headlight_code[1:0];
        cur_mode_q      <= item_q.mode_code;
        cur_flags_q     <= {item_q.hand_brake_on, item_q.horn_on};
        cur_speed_q     <= item_q.speed;
      end
      for (int i = 0; i < PendN; i++) begin
        pend_val_q[i]   <= pend_val_d[i];
        pend_stamp_q[i] <= pend_stamp_d[i];
      end
    end
  end

endmodule

[rtl/vehicle_command_safety_supervisor_unit.sv]
// Vehicle command safety supervisor, top level.
// Commands and reports pass through clamp, multiply and finish to the result beat;
// a timeout tick also passes the one-bit-per-cycle braking divider (35 steps).
// A new item is taken only after the previous result has moved into the result register.
// Reset: asynchronous, active low; restores config defaults, vehicle state and requests.
module vehicle_command_safety_supervisor_unit import vcss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  vcss_in_if.sink     cmd_i,
  vcss_out_if.source  res_o,
  vcss_cfg_if.sink    cfg_i
);

  dp_cmd_t   dp_cmd;
  dp_stat_t  dp_stat;
  in_item_t  item;
  out_item_t res;

  // Pack the input beat
  assign item.action          = cmd_i.action;
  assign item.accel_cmd       = cmd_i.accel_cmd;
  assign item.wheel_angle_cmd = cmd_i.wheel_angle_cmd;
  assign item.speed           = cmd_i.speed;
  assign item.headlight_code  = cmd_i.headlight_code;
  assign item.blinker_code    = cmd_i.blinker_code;
  assign item.wiper_code      = cmd_i.wiper_code;
  assign item.gear_code       = cmd_i.gear_code;
  assign item.mode_code       = cmd_i.mode_code;
  assign item.horn_on         = cmd_i.horn_on;
  assign item.hand_brake_on   = cmd_i.hand_brake_on;
  assign item.time_stamp      = cmd_i.time_stamp;

  // Config writes always land
  assign cfg_i.ready = 1'b1;

  vcss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  vcss_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .item_i     (item),
    .res_o      (res)
  );

  // Unpack the result beat
  assign res_o.accel_out       = res.accel_out;
  assign res_o.wheel_angle_out = res.wheel_angle_out;
  assign res_o.has_state_cmd   = res.has_state_cmd;
  assign res_o.headlight_out   = res.headlight_out;
  assign res_o.blinker_out     = res.blinker_out;
  assign res_o.wiper_out       = res.wiper_out;
  assign res_o.gear_out        = res.gear_out;
  assign res_o.mode_out        = res.mode_out;
  assign res_o.horn_out        = res.horn_out;
  assign res_o.hand_brake_out  = res.hand_brake_out;
  assign res_o.report_flags    = res.report_flags;
  assign res_o.stamp_out       = res.stamp_out;

endmodule

[dv/tb_vehicle_command_safety_supervisor_unit.sv]
// Testbench for the vehicle command safety supervisor: directed and random items
// checked against a cycle-free predictor. Depends on vcss_pkg, vcss_ifs and the top level.
`timescale 1ns / 1ps
module tb_vehicle_command_safety_supervisor_unit;
  import vcss_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vcss_in_if  cmd_if ();
  vcss_out_if res_if ();
  vcss_cfg_if cfg_if ();

  vehicle_command_safety_supervisor_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Toggle the clock every half period
  always #5 clk_i = ~clk_i;

  // Supervisor settings as the predictor sees them
  int          lim_acc_lo, lim_acc_hi, lim_wa_lo, lim_wa_hi, lim_spd, lim_dead;
  int unsigned step_us, trans_us;
  // Vehicle state and open requests
  logic [2:0]  veh_gear, veh_blinker, veh_wiper;
  logic [1:0]  veh_headlight, veh_mode, veh_flags;
  int          veh_speed;
  logic [2:0]  req_val [PendN];
  logic [47:0] req_stamp [PendN];

  out_item_t   pending_res [$];
  int          n_fail = 0;
  int          n_res = 0;
  int          n_items = 0;
  bit          sink_stall_en = 1'b1;

  function automatic int unsigned eff_step();
    return (step_us == 0) ? 1 : step_us;
  endfunction

  function automatic bit speed_high();
    return veh_speed > lim_spd || veh_speed < -lim_spd;
  endfunction

  // Pick drive or reverse when the commanded accel turns the car around
  function automatic logic [2:0] shift_pick(int a, logic [2:0] g);
    longint vn;
    int     mag;
    bit     flips;
    mag = (a < 0) ? -a : a;
    if (g == GR_PRK || mag < lim_dead || speed_high()) return g;
    if ((a > 0 && veh_speed > 0) || (a < 0 && veh_speed < 0)) return g;
    vn = longint'(veh_speed) * 1000000 + longint'(a) * longint'(eff_step());
    flips = (veh_speed > 0 && vn < 0) || (veh_speed < 0 && vn > 0);
    if (veh_speed != 0 && !flips) return g;
    return (a > 0) ? GR_DRV : GR_RVS;
  endfunction

  function automatic bit fwd(logic [2:0] g);
    return g == GR_DRV || g == GR_LO;
  endfunction

  function automatic int clip(int v, int lo, int hi, ref bit hit);
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    return v;
  endfunction

  function automatic bit is_late(int i, logic [47:0] st);
    return {16'd0, st} > {16'd0, req_stamp[i]} + 64'(trans_us);
  endfunction

  function automatic void note_req(int i, logic [2:0] c, logic [2:0] cur, logic [47:0] st,
                                   bit is_flag);
    if ((is_flag || c != 0) && c != cur) begin
      req_val[i] = c;
      req_stamp[i] = st;
    end
  endfunction

  function automatic bit req_missed(int i, logic [2:0] rep, logic [47:0] st);
    if (req_val[i] == 0) return 1'b0;
    if (req_val[i] == rep) begin
      req_val[i] = 0;
      req_stamp[i] = '0;
      return 1'b0;
    end
    return is_late(i, st);
  endfunction

  function automatic void reset_model();
    lim_acc_lo = -768; lim_acc_hi = 768; lim_wa_lo = -4096; lim_wa_hi = 4096;
    lim_spd = 128; step_us = 100000; trans_us = 3000000; lim_dead = 128;
    veh_gear = GR_DRV; veh_blinker = BL_OFF; veh_wiper = WP_OFF;
    veh_headlight = 2'(HL_OFF); veh_mode = MD_NRDY; veh_flags = '0; veh_speed = 0;
    for (int i = 0; i < PendN; i++) begin
      req_val[i] = '0;
      req_stamp[i] = '0;
    end
  endfunction

  function automatic void apply_setting(logic [2:0] idx, logic [31:0] d);
    case (idx)
      CFG_ACCEL_MIN:   lim_acc_lo = int'($signed(d[15:0]));
      CFG_ACCEL_MAX:   lim_acc_hi = int'(d[14:0]);
      CFG_WA_MIN:      lim_wa_lo = int'($signed(d[15:0]));
      CFG_WA_MAX:      lim_wa_hi = int'(d[14:0]);
      CFG_SPEED_LIMIT: lim_spd = int'(d[14:0]);
      CFG_STEP_US:     step_us = d[19:0];
      CFG_TIMEOUT_US:  trans_us = d;
      CFG_DEADZONE:    lim_dead = int'(d[14:0]);
      default: ;
    endcase
  endfunction

  // Work out the supervised command for one item and advance the state
  function automatic out_item_t supervise(in_item_t it);
    out_item_t r;
    bit        hit, bad, late_any;
    int        a, w;
    longint    q;
    logic [2:0] hl, bl, wp, gr, g;
    logic [1:0] md;
    hit = 0; bad = 0; late_any = 0;
    r = '0;
    r.stamp_out = it.time_stamp;
    hl = it.headlight_code; bl = it.blinker_code; wp = it.wiper_code;
    gr = it.gear_code; md = it.mode_code;
    case (it.action)
      ACT_CMD_STATE, ACT_CMD: begin
        a = clip(int'($signed(it.accel_cmd)), lim_acc_lo, lim_acc_hi, hit);
        w = clip(int'($signed(it.wheel_angle_cmd)), lim_wa_lo, lim_wa_hi, hit);
        r.accel_out = 16'(a);
        r.wheel_angle_out = 16'(w);
        r.report_flags[0] = hit;
        if (it.action == ACT_CMD_STATE) begin
          if (hl > HL_HIGH) begin hl = HL_NONE; bad = 1; end
          if (bl > BL_HAZARD) begin bl = BL_NONE; bad = 1; end
          if (wp > WP_CLEAN) begin wp = WP_NONE; bad = 1; end
          if (gr > GR_NEU) begin gr = GR_NONE; bad = 1; end
          if (md == MD_NRDY) begin md = MD_NONE; bad = 1; end
          r.report_flags[1] = bad;
          if ((wp == WP_LOW || wp == WP_HIGH) && hl <= HL_OFF) begin
            hl = HL_LOW;
            r.report_flags[2] = 1'b1;
          end
          g = shift_pick(a, gr);
          gr = (g == veh_gear) ? GR_NONE : g;
          // Drop a gear change that is unsafe at speed
          if (gr != GR_NONE && speed_high() && (fwd(veh_gear) != fwd(gr) || veh_gear != gr))
          begin
            gr = GR_NONE;
            r.report_flags[3] = 1'b1;
          end
          note_req(PendWiper, wp, veh_wiper, it.time_stamp, 0);
          note_req(PendBlinker, bl, veh_blinker, it.time_stamp, 0);
          note_req(PendGear, gr, veh_gear, it.time_stamp, 0);
          note_req(PendHeadlight, hl, {1'b0, veh_headlight}, it.time_stamp, 0);
          note_req(PendMode, {1'b0, md}, {1'b0, veh_mode}, it.time_stamp, 0);
          note_req(PendHorn, {2'b0, it.horn_on}, {2'b0, veh_flags[0]}, it.time_stamp, 1);
          note_req(PendHandBrake, {2'b0, it.hand_brake_on}, {2'b0, veh_flags[1]},
                   it.time_stamp, 1);
          r.has_state_cmd = 1'b1;
          r.headlight_out = hl[1:0]; r.blinker_out = bl; r.wiper_out = wp;
          r.gear_out = gr; r.mode_out = md;
          r.horn_out = it.horn_on; r.hand_brake_out = it.hand_brake_on;
        end else begin
          g = shift_pick(a, veh_gear);
          if (g != veh_gear) begin
            r.has_state_cmd = 1'b1;
            r.gear_out = g;
          end
        end
      end
      ACT_REPORT: begin
        veh_speed = int'($signed(it.speed));
        veh_gear = gr; veh_blinker = bl; veh_wiper = wp;
        veh_headlight = hl[1:0]; veh_mode = md;
        veh_flags = {it.hand_brake_on, it.horn_on};
        late_any |= req_missed(PendGear, veh_gear, it.time_stamp);
        late_any |= req_missed(PendBlinker, veh_blinker, it.time_stamp);
        late_any |= req_missed(PendWiper, veh_wiper, it.time_stamp);
        late_any |= req_missed(PendHeadlight, {1'b0, veh_headlight}, it.time_stamp);
        late_any |= req_missed(PendMode, {1'b0, veh_mode}, it.time_stamp);
        if (req_val[PendHorn] != {2'b0, it.horn_on})
          late_any |= is_late(PendHorn, it.time_stamp);
        if (req_val[PendHandBrake] != {2'b0, it.hand_brake_on})
          late_any |= is_late(PendHandBrake, it.time_stamp);
        r.report_flags[4] = late_any;
      end
      default: begin
        // Brake to a stop within one step
        q = -(longint'(veh_speed) * 1000000) / longint'(eff_step());
        if (q < lim_acc_lo) q = lim_acc_lo;
        else if (q > lim_acc_hi) q = lim_acc_hi;
        r.accel_out = 16'(q);
        r.has_state_cmd = 1'b1;
        r.blinker_out = BL_HAZARD;
      end
    endcase
    return r;
  endfunction

  // Hold the sender idle before the first item
  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.action = '0; cmd_if.accel_cmd = '0; cmd_if.wheel_angle_cmd = '0;
    cmd_if.speed = '0; cmd_if.headlight_code = '0; cmd_if.blinker_code = '0;
    cmd_if.wiper_code = '0; cmd_if.gear_code = '0; cmd_if.mode_code = '0;
    cmd_if.horn_on = 1'b0; cmd_if.hand_brake_on = 1'b0; cmd_if.time_stamp = '0;
    cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
    res_if.ready = 1'b0;
  end

  // Drive ready with random stalls per beat
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = sink_stall_en ? $urandom_range(0, 3) : 0;
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
    end
  end

  // Compare every result beat with the oldest expected result
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      n_res++;
      if (pending_res.size() == 0) begin
        $error("result beat with nothing expected");
        n_fail++;
      end else begin
        e = pending_res.pop_front();
        if (res_if.accel_out !== e.accel_out) begin
          $error("accel_out exp %h got %h", e.accel_out, res_if.accel_out); n_fail++;
        end
        if (res_if.wheel_angle_out !== e.wheel_angle_out) begin
          $error("wheel_angle_out exp %h got %h", e.wheel_angle_out, res_if.wheel_angle_out);
          n_fail++;
        end
        if (res_if.has_state_cmd !== e.has_state_cmd) begin
          $error("has_state_cmd exp %h got %h", e.has_state_cmd, res_if.has_state_cmd);
          n_fail++;
        end
        if (res_if.headlight_out !== e.headlight_out) begin
          $error("headlight_out exp %h got %h", e.headlight_out, res_if.headlight_out);
          n_fail++;
        end
        if (res_if.blinker_out !== e.blinker_out) begin
          $error("blinker_out exp %h got %h", e.blinker_out, res_if.blinker_out); n_fail++;
        end
        if (res_if.wiper_out !== e.wiper_out) begin
          $error("wiper_out exp %h got %h", e.wiper_out, res_if.wiper_out); n_fail++;
        end
        if (res_if.gear_out !== e.gear_out) begin
          $error("gear_out exp %h got %h", e.gear_out, res_if.gear_out); n_fail++;
        end
        if (res_if.mode_out !== e.mode_out) begin
          $error("mode_out exp %h got %h", e.mode_out, res_if.mode_out); n_fail++;
        end
        if (res_if.horn_out !== e.horn_out) begin
          $error("horn_out exp %h got %h", e.horn_out, res_if.horn_out); n_fail++;
        end
        if (res_if.hand_brake_out !== e.hand_brake_out) begin
          $error("hand_brake_out exp %h got %h", e.hand_brake_out, res_if.hand_brake_out);
          n_fail++;
        end
        if (res_if.report_flags !== e.report_flags) begin
          $error("report_flags exp %h got %h", e.report_flags, res_if.report_flags);
          n_fail++;
        end
        if (res_if.stamp_out !== e.stamp_out) begin
          $error("stamp_out exp %h got %h", e.stamp_out, res_if.stamp_out); n_fail++;
        end
      end
    end
  end

  // Send one item beat after a random gap, predicting its result on acceptance
  task automatic send_item(in_item_t it);
    int gap;
    @(negedge clk_i);
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.action <= it.action; cmd_if.accel_cmd <= it.accel_cmd;
    cmd_if.wheel_angle_cmd <= it.wheel_angle_cmd; cmd_if.speed <= it.speed;
    cmd_if.headlight_code <= it.headlight_code; cmd_if.blinker_code <= it.blinker_code;
    cmd_if.wiper_code <= it.wiper_code; cmd_if.gear_code <= it.gear_code;
    cmd_if.mode_code <= it.mode_code; cmd_if.horn_on <= it.horn_on;
    cmd_if.hand_brake_on <= it.hand_brake_on; cmd_if.time_stamp <= it.time_stamp;
    do @(posedge clk_i); while (!(cmd_if.valid && cmd_if.ready));
    pending_res.push_back(supervise(it));
    n_items++;
  endtask

  // Drop valid and wait for every expected result
  task automatic drain();
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic write_setting(logic [2:0] idx, logic [31:0] d);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= d;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    apply_setting(idx, d);
  endtask

  task automatic write_all(int amin, int amax, int wmin, int wmax, int spd,
                           int unsigned stp, int unsigned tmo, int dz);
    write_setting(CFG_ACCEL_MIN, 32'(amin));
    write_setting(CFG_ACCEL_MAX, 32'(amax));
    write_setting(CFG_WA_MIN, 32'(wmin));
    write_setting(CFG_WA_MAX, 32'(wmax));
    write_setting(CFG_SPEED_LIMIT, 32'(spd));
    write_setting(CFG_STEP_US, stp);
    write_setting(CFG_TIMEOUT_US, tmo);
    write_setting(CFG_DEADZONE, 32'(dz));
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic in_item_t rand_item(logic [1:0] act, logic [47:0] st);
    in_item_t it;
    it.action = act;
    it.accel_cmd = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000) - 1000);
    it.wheel_angle_cmd = 16'($urandom);
    it.speed = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600) - 300);
    it.headlight_code = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 3));
    it.blinker_code = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4));
    it.wiper_code = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4));
    it.gear_code = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 5));
    it.mode_code = 2'($urandom);
    it.horn_on = 1'($urandom);
    it.hand_brake_on = 1'($urandom);
    it.time_stamp = st;
    return it;
  endfunction

  // Directed: extremes, each action, bad codes, wiper headlights, shifts, timeout
  task automatic test_directed();
    in_item_t it;
    it = rand_item(ACT_CMD_STATE, 48'd10);
    it.accel_cmd = 16'h8000; it.wheel_angle_cmd = 16'h7fff;
    it.headlight_code = 3'd7; it.blinker_code = 3'd7; it.wiper_code = 3'd7;
    it.gear_code = 3'd7; it.mode_code = MD_NRDY;
    send_item(it);
    it = rand_item(ACT_CMD_STATE, 48'd20);
    it.accel_cmd = 16'h7fff; it.wheel_angle_cmd = 16'h8000;
    it.wiper_code = WP_LOW; it.headlight_code = HL_OFF; it.gear_code = GR_RVS;
    send_item(it);
    it = rand_item(ACT_CMD, 48'd30);
    it.accel_cmd = -16'sd500;
    send_item(it);
    it = rand_item(ACT_REPORT, 48'hffff_ffff_ffff);
    it.speed = 16'h7fff; it.gear_code = GR_DRV;
    send_item(it);
    it = rand_item(ACT_CMD_STATE, 48'd40);
    it.gear_code = GR_RVS; it.wiper_code = WP_HIGH; it.headlight_code = HL_NONE;
    send_item(it);
    it = rand_item(ACT_TIMEOUT, 48'd50);
    send_item(it);
    it = rand_item(ACT_REPORT, 48'd60);
    it.speed = 16'h8000; it.gear_code = GR_RVS;
    send_item(it);
    it = rand_item(ACT_TIMEOUT, 48'd70);
    send_item(it);
    it = rand_item(ACT_REPORT, 48'd80);
    it.speed = 16'sd50; it.gear_code = GR_DRV;
    send_item(it);
    it = rand_item(ACT_CMD, 48'd90);
    it.accel_cmd = -16'sd700;
    send_item(it);
    it = rand_item(ACT_REPORT, 48'h0);
    it.speed = 16'h0; it.gear_code = GR_PRK; it.headlight_code = 3'd6;
    send_item(it);
    it = rand_item(ACT_CMD_STATE, 48'd100);
    it.accel_cmd = 16'sd600; it.gear_code = GR_NONE;
    send_item(it);
    drain();
  endtask

  // Random episodes: requests followed by matching, late or wrong reports
  task automatic test_random(int n);
    logic [47:0] stamp;
    in_item_t    it;
    int          r;
    stamp = 48'($urandom_range(0, 1000));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      stamp += ($urandom_range(0, 3) == 0) ? 48'($urandom_range(0, 8000000))
                                            : 48'($urandom_range(0, 200000));
      if (r < 3) it = rand_item(ACT_CMD_STATE, stamp);
      else if (r < 5) it = rand_item(ACT_CMD, stamp);
      else if (r < 9) begin
        it = rand_item(ACT_REPORT, stamp);
        // Often report what was asked for, so requests get satisfied
        if ($urandom_range(0, 1)) begin
          if (req_val[PendGear] != 0) it.gear_code = req_val[PendGear];
          if (req_val[PendWiper] != 0) it.wiper_code = req_val[PendWiper];
          if (req_val[PendBlinker] != 0) it.blinker_code = req_val[PendBlinker];
          if (req_val[PendHeadlight] != 0) it.headlight_code = req_val[PendHeadlight];
          if (req_val[PendMode] != 0) it.mode_code = req_val[PendMode][1:0];
        end
      end else it = rand_item(ACT_TIMEOUT, stamp);
      if ($urandom_range(0, 60) == 0) it.time_stamp = 48'($urandom) << 16 | 48'($urandom);
      send_item(it);
      // Let everything drain once mid-run
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    reset_model();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(150);
    write_all(-32768, 0, -32768, 0, 1, 0, 1, 1);
    test_random(120);
    write_all(0, 32767, 0, 32767, 32767, 1000000, 32'hffff_ffff, 32767);
    test_random(120);
    // Crossed limits: the minimum check comes first
    write_all(100, 50, 200, 100, 300, 1, 50000, 64);
    sink_stall_en = 1'b0;
    test_random(80);
    sink_stall_en = 1'b1;
    write_all(-1000, 1000, -8000, 8000, 200, 33333, 1500000, 200);
    test_random(130);
    $display("covered %0d items and %0d results over five settings", n_items, n_res);
    if (n_fail == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Give up after a generous fixed time
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
